/* hdl/kf4_pkg.sv */
// ----------------------------------------------------------------------------
// kf4_pkg
// shared widths, codes and control structs of the four-state kalman filter
// ----------------------------------------------------------------------------
package kf4_pkg;

  // action codes
  localparam logic [1:0] ACT_PREDICT = 2'd0;
  localparam logic [1:0] ACT_UPDATE  = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  // operand and accumulator widths of the shared multiply-accumulate unit
  localparam int OPA_W  = 40;
  localparam int OPB_W  = 33;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = 74;

  // divider widths
  localparam int NUM_W     = 65;
  localparam int GAIN_FRAC = 24;
  localparam int DVD_W     = 64 + GAIN_FRAC;
  localparam int DIV_STEPS = DVD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // accumulator operations
  localparam logic [1:0] MAC_NOP  = 2'd0;
  localparam logic [1:0] MAC_LOAD = 2'd1;
  localparam logic [1:0] MAC_ADD  = 2'd2;
  localparam logic [1:0] MAC_SUB  = 2'd3;

  typedef struct packed {
    logic                    mul;
    logic [1:0]              op;
    logic signed [OPA_W-1:0] a;
    logic signed [OPB_W-1:0] b;
  } mac_cmd_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [NUM_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quo;
  } div_rsp_t;

endpackage

/* hdl/kf4_if.sv */
// ----------------------------------------------------------------------------
// kf4 channel interfaces
// command channel into the filter and estimate channel out of it
// ----------------------------------------------------------------------------
interface kf4_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] control_input;
  logic signed [31:0] measured_position;
  logic signed [31:0] measured_angle;

  modport source (output valid, action, control_input, measured_position, measured_angle,
                  input ready);
  modport sink (input valid, action, control_input, measured_position, measured_angle,
                output ready);
endinterface

interface kf4_est_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] est_position;
  logic signed [31:0] est_velocity;
  logic signed [31:0] est_angle;
  logic signed [31:0] est_angular_rate;
  logic               singular;

  modport source (output valid, est_position, est_velocity, est_angle, est_angular_rate,
                  singular, input ready);
  modport sink (input valid, est_position, est_velocity, est_angle, est_angular_rate,
                singular, output ready);
endinterface

/* hdl/kf4_mac.sv */
// ----------------------------------------------------------------------------
// kf4_mac
// shared signed multiplier with registered product and accumulator
// ----------------------------------------------------------------------------
module kf4_mac import kf4_pkg::*; (
  input  logic                    clk,
  input  mac_cmd_t                cmd,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext;

  assign prod_ext = ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= cmd.a * cmd.b;
    end
    case (cmd.op)
      MAC_LOAD: acc <= prod_ext;
      MAC_ADD:  acc <= acc + prod_ext;
      MAC_SUB:  acc <= acc - prod_ext;
      default:  acc <= acc;
    endcase
  end

endmodule

/* hdl/kf4_div.sv */
// ----------------------------------------------------------------------------
// kf4_div
// radix-2 restoring divider for the gain, quotient scaled by 2^24, saturating
// ----------------------------------------------------------------------------
module kf4_div import kf4_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] dvd;
  logic [63:0]      rem;
  logic [63:0]      dsr;
  logic [31:0]      q;
  logic             ovf;
  logic             neg;

  logic [NUM_W-1:0] num_abs;
  logic [NUM_W-1:0] den_abs;
  logic [64:0]      rem_sh;
  logic [64:0]      rem_sub;
  logic             qb;

  assign num_abs = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
  assign den_abs = req.den[NUM_W-1] ? NUM_W'(-req.den) : NUM_W'(req.den);
  assign rem_sh  = {rem, dvd[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr};
  assign qb      = (rem_sh >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= {num_abs[63:0], {GAIN_FRAC{1'b0}}};
        dsr  <= den_abs[63:0];
        rem  <= '0;
        q    <= '0;
        ovf  <= 1'b0;
        neg  <= req.num[NUM_W-1] ^ req.den[NUM_W-1];
      end else if (busy) begin
        rem <= qb ? rem_sub[63:0] : rem_sh[63:0];
        q   <= {q[30:0], qb};
        ovf <= ovf | q[31];
        dvd <= {dvd[DVD_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // saturate to the signed 32-bit gain range
  always_comb begin
    rsp.done = done;
    if (ovf || q[31]) begin
      rsp.quo = neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      rsp.quo = neg ? -$signed(q) : $signed(q);
    end
  end

endmodule

/* hdl/kalman_filter_four_state.sv */
// ----------------------------------------------------------------------------
// kalman_filter_four_state
// four-state, two-measurement fixed-point kalman filter on one shared
// multiply-accumulate unit and one serial divider under a sequencer
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake        payload
//  cmd      in         valid/ready      action, control_input, measured_position,
//                                       measured_angle
//  est      out        valid/ready      est_position, est_velocity, est_angle,
//                                       est_angular_rate, singular
//  apb      in         psel/penable     six 64-bit registers at 8*i, pready tied high
//
//  predict takes 148 products on the shared multiplier, each a product phase then an accumulate phase
//  update takes eight gain divisions in the divider, run one after another
//  restart and the unused action go straight to loading the output register
//  cmd is ready only in idle; a finished estimate waits in the output register
//  reset is synchronous: estimates zero, covariance identity, registers to defaults
//
module kalman_filter_four_state import kf4_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  kf4_cmd_if.sink     cmd,
  kf4_est_if.source   est,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // register indexes
  localparam logic [2:0] REG_A_ROW0 = 3'd0;
  localparam logic [2:0] REG_A_ROW1 = 3'd1;
  localparam logic [2:0] REG_A_ROW2 = 3'd2;
  localparam logic [2:0] REG_A_ROW3 = 3'd3;
  localparam logic [2:0] REG_B_VEC  = 3'd4;
  localparam logic [2:0] REG_INIT   = 3'd5;

  // sequencer states
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_PX_MAC  = 5'd1;
  localparam logic [4:0] S_PX_WR   = 5'd2;
  localparam logic [4:0] S_PX_CP   = 5'd3;
  localparam logic [4:0] S_PA_MAC  = 5'd4;
  localparam logic [4:0] S_PA_WR   = 5'd5;
  localparam logic [4:0] S_PP_MAC  = 5'd6;
  localparam logic [4:0] S_PP_WR   = 5'd7;
  localparam logic [4:0] S_US      = 5'd8;
  localparam logic [4:0] S_UD_MAC  = 5'd9;
  localparam logic [4:0] S_UD_WR   = 5'd10;
  localparam logic [4:0] S_UY      = 5'd11;
  localparam logic [4:0] S_UN_MAC  = 5'd12;
  localparam logic [4:0] S_UN_WR   = 5'd13;
  localparam logic [4:0] S_UN_WAIT = 5'd14;
  localparam logic [4:0] S_UX_MAC  = 5'd15;
  localparam logic [4:0] S_UX_ADD  = 5'd16;
  localparam logic [4:0] S_UP_MAC  = 5'd17;
  localparam logic [4:0] S_UP_ADD  = 5'd18;
  localparam logic [4:0] S_UP_CP   = 5'd19;
  localparam logic [4:0] S_FIN     = 5'd20;

  // fixed-point constants in q4.28
  localparam logic signed [31:0] ONE_P = 32'sd268435456;
  localparam logic signed [31:0] Q_D0  = 32'sd268435;
  localparam logic signed [31:0] Q_D1  = 32'sd268435456;
  localparam logic signed [31:0] Q_D2  = 32'sd26844;
  localparam logic signed [31:0] Q_D3  = 32'sd2684355;
  localparam logic signed [31:0] R_D0  = 32'sd13421773;
  localparam logic signed [31:0] R_D1  = 32'sd1342177;

  localparam int TS_W = 44;
  localparam logic signed [ACC_W-1:0] HALF11 = ACC_W'(1024);
  localparam logic signed [ACC_W-1:0] HALF24 = ACC_W'(8388608);

  // signed q5.11 entry j of a packed register
  function automatic logic signed [15:0] field16(input logic [63:0] w, input logic [1:0] j);
    return w[{j, 4'b0000} +: 16];
  endfunction

  function automatic logic signed [31:0] q_diag(input logic [1:0] i);
    case (i)
      2'd0:    return Q_D0;
      2'd1:    return Q_D1;
      2'd2:    return Q_D2;
      default: return Q_D3;
    endcase
  endfunction

  // round half up, then arithmetic shift
  function automatic logic signed [ACC_W-1:0] rnd11(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v + HALF11;
    return t >>> 11;
  endfunction

  function automatic logic signed [ACC_W-1:0] rnd24(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v + HALF24;
    return t >>> GAIN_FRAC;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(32'sh7fff_ffff)) return 32'sh7fff_ffff;
    if (v < ACC_W'(32'sh8000_0000)) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] ext32(input logic signed [31:0] v);
    return {{(ACC_W-32){v[31]}}, v};
  endfunction

  function automatic logic signed [ACC_W-1:0] ext_ts(input logic signed [TS_W-1:0] v);
    return {{(ACC_W-TS_W){v[TS_W-1]}}, v};
  endfunction

  // configuration registers
  logic [63:0] a_row [4];
  logic [63:0] b_vec;
  logic [63:0] init_est;

  // filter state and scratch
  logic signed [31:0]      x    [4];
  logic signed [31:0]      xn   [4];
  logic signed [31:0]      cov  [16];
  logic signed [OPA_W-1:0] ap   [16];
  logic signed [31:0]      kg   [8];
  logic signed [31:0]      s00, s01, s10, s11;
  logic signed [NUM_W-1:0] det;
  logic signed [32:0]      y0, y1;
  logic signed [TS_W-1:0]  tsum;
  logic signed [31:0]      u, zx, zt;
  logic                    sing;

  // sequencer
  logic [4:0] state;
  logic [1:0] ci, cj;
  logic [2:0] k;
  logic       ph;
  logic [2:0] klast;
  logic [4:0] wr_state;
  logic [3:0] p_addr;
  logic signed [31:0] p_rd;
  logic [2:0] gidx;
  logic       fin_load;

  mac_cmd_t                mac_cmd;
  logic signed [ACC_W-1:0] acc;
  div_req_t                div_req;
  div_rsp_t                div_rsp;
  logic                    div_start;

  logic signed [ACC_W-1:0] acc_r11;
  logic signed [ACC_W-1:0] acc_q24;
  logic signed [TS_W-1:0]  acc_r24;

  assign acc_r11  = rnd11(acc);
  assign acc_q24  = rnd24(acc);
  assign acc_r24  = acc_q24[TS_W-1:0];
  assign p_rd     = cov[p_addr];
  assign gidx     = {ci, cj[0]};
  assign fin_load = (state == S_FIN) && (!est.valid || est.ready);

  kf4_mac u_mac (
    .clk (clk),
    .cmd (mac_cmd),
    .acc (acc)
  );

  assign div_req.start = div_start;
  assign div_req.num   = acc[NUM_W-1:0];
  assign div_req.den   = det;

  kf4_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // apb side: always ready, reads return the register
  assign pready = 1'b1;

  always_comb begin
    case (paddr[5:3])
      REG_A_ROW0: prdata = a_row[0];
      REG_A_ROW1: prdata = a_row[1];
      REG_A_ROW2: prdata = a_row[2];
      REG_A_ROW3: prdata = a_row[3];
      REG_B_VEC:  prdata = b_vec;
      REG_INIT:   prdata = init_est;
      default:    prdata = '0;
    endcase
  end

  assign cmd.ready = (state == S_IDLE);

  // covariance read address for the state at hand
  always_comb begin
    case (state)
      S_PA_MAC: p_addr = {k[1:0], cj};
      S_UN_MAC: p_addr = {ci, cj[0] ^ k[0], 1'b0};
      S_UP_MAC: p_addr = {k[0], 1'b0, cj};
      S_UP_ADD: p_addr = {ci, cj};
      default:  p_addr = '0;
    endcase
  end

  // last term and write-back state of each accumulate loop
  always_comb begin
    case (state)
      S_PX_MAC: begin klast = 3'd4; wr_state = S_PX_WR; end
      S_PA_MAC: begin klast = 3'd3; wr_state = S_PA_WR; end
      S_PP_MAC: begin klast = 3'd3; wr_state = S_PP_WR; end
      S_UD_MAC: begin klast = 3'd1; wr_state = S_UD_WR; end
      S_UN_MAC: begin klast = 3'd1; wr_state = S_UN_WR; end
      default:  begin klast = 3'd0; wr_state = S_IDLE; end
    endcase
  end

  // operand selection for the shared multiplier
  always_comb begin
    mac_cmd.mul = 1'b0;
    mac_cmd.op  = MAC_NOP;
    mac_cmd.a   = '0;
    mac_cmd.b   = '0;
    case (state)
      S_PX_MAC: begin
        if (k == 3'd0) begin
          mac_cmd.a = OPA_W'(field16(b_vec, ci));
          mac_cmd.b = OPB_W'(u);
        end else begin
          mac_cmd.a = OPA_W'(field16(a_row[ci], 2'(k - 3'd1)));
          mac_cmd.b = OPB_W'(x[2'(k - 3'd1)]);
        end
      end
      S_PA_MAC: begin
        mac_cmd.a = OPA_W'(field16(a_row[ci], k[1:0]));
        mac_cmd.b = OPB_W'(p_rd);
      end
      S_PP_MAC: begin
        mac_cmd.a = ap[{ci, k[1:0]}];
        mac_cmd.b = OPB_W'(field16(a_row[cj], k[1:0]));
      end
      S_UD_MAC: begin
        mac_cmd.a = k[0] ? OPA_W'(s10) : OPA_W'(s00);
        mac_cmd.b = k[0] ? OPB_W'(s01) : OPB_W'(s11);
      end
      S_UN_MAC: begin
        // column 0: p0*s11 - p2*s10, column 1: p2*s00 - p0*s01
        mac_cmd.a = OPA_W'(p_rd);
        case ({cj[0], k[0]})
          2'b00:   mac_cmd.b = OPB_W'(s11);
          2'b01:   mac_cmd.b = OPB_W'(s10);
          2'b10:   mac_cmd.b = OPB_W'(s00);
          default: mac_cmd.b = OPB_W'(s01);
        endcase
      end
      S_UX_MAC: begin
        mac_cmd.a = OPA_W'(kg[{ci, k[0]}]);
        mac_cmd.b = k[0] ? y1 : y0;
      end
      S_UP_MAC: begin
        mac_cmd.a = OPA_W'(kg[{ci, k[0]}]);
        mac_cmd.b = OPB_W'(p_rd);
      end
      default: ;
    endcase
    case (state)
      S_PX_MAC, S_PA_MAC, S_PP_MAC, S_UD_MAC, S_UN_MAC: begin
        mac_cmd.mul = !ph;
        if (ph) begin
          if (k == 3'd0) mac_cmd.op = MAC_LOAD;
          else if (state == S_UD_MAC || state == S_UN_MAC) mac_cmd.op = MAC_SUB;
          else mac_cmd.op = MAC_ADD;
        end
      end
      S_UX_MAC, S_UP_MAC: begin
        mac_cmd.mul = !ph;
        if (ph) mac_cmd.op = MAC_LOAD;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ci        <= '0;
      cj        <= '0;
      k         <= '0;
      ph        <= 1'b0;
      sing      <= 1'b0;
      div_start <= 1'b0;
      est.valid <= 1'b0;
      a_row[0]  <= 64'd2048;
      a_row[1]  <= 64'd134217728;
      a_row[2]  <= 64'd8796093022208;
      a_row[3]  <= 64'd576460752303423488;
      b_vec     <= '0;
      init_est  <= '0;
      for (int i = 0; i < 4; i++) x[i] <= '0;
      for (int i = 0; i < 16; i++) cov[i] <= (i % 5 == 0) ? ONE_P : '0;
    end else begin
      div_start <= 1'b0;

      // apb write on the access cycle
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_A_ROW0: a_row[0] <= pwdata;
          REG_A_ROW1: a_row[1] <= pwdata;
          REG_A_ROW2: a_row[2] <= pwdata;
          REG_A_ROW3: a_row[3] <= pwdata;
          REG_B_VEC:  b_vec    <= pwdata;
          REG_INIT:   init_est <= pwdata;
          default: ;
        endcase
      end

      // estimate transfer drains the output register
      if (est.valid && est.ready && !fin_load) est.valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            u    <= cmd.control_input;
            zx   <= cmd.measured_position;
            zt   <= cmd.measured_angle;
            ci   <= '0;
            cj   <= '0;
            k    <= '0;
            ph   <= 1'b0;
            sing <= 1'b0;
            case (cmd.action)
              ACT_PREDICT: state <= S_PX_MAC;
              ACT_UPDATE:  state <= S_US;
              ACT_RESTART: begin
                // q8.8 restart values widened to q16.16, identity covariance
                for (int i = 0; i < 4; i++) begin
                  x[i] <= {{8{init_est[16*i+15]}}, init_est[16*i +: 16], 8'h00};
                end
                for (int i = 0; i < 16; i++) cov[i] <= (i % 5 == 0) ? ONE_P : '0;
                state <= S_FIN;
              end
              default: state <= S_FIN;
            endcase
          end
        end

        // product on the first phase, accumulate on the second, term counter k
        S_PX_MAC, S_PA_MAC, S_PP_MAC, S_UD_MAC, S_UN_MAC: begin
          if (!ph) begin
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            if (k == klast) begin
              k     <= '0;
              state <= wr_state;
            end else begin
              k <= k + 3'd1;
            end
          end
        end

        // predicted state x = A*x + B*u
        S_PX_WR: begin
          xn[ci] <= sat32(acc_r11);
          ci     <= ci + 2'd1;
          state  <= (ci == 2'd3) ? S_PX_CP : S_PX_MAC;
        end
        S_PX_CP: begin
          x     <= xn;
          state <= S_PA_MAC;
        end

        // A*P into scratch
        S_PA_WR: begin
          ap[{ci, cj}] <= acc_r11[OPA_W-1:0];
          {ci, cj}     <= {ci, cj} + 4'd1;
          state        <= ({ci, cj} == 4'd15) ? S_PP_MAC : S_PA_MAC;
        end

        // (A*P)*A' plus process noise on the diagonal
        S_PP_WR: begin
          cov[{ci, cj}] <= sat32(acc_r11 + ((ci == cj) ? ext32(q_diag(ci)) : '0));
          {ci, cj}      <= {ci, cj} + 4'd1;
          state         <= ({ci, cj} == 4'd15) ? S_FIN : S_PP_MAC;
        end

        // innovation covariance
        S_US: begin
          s00   <= sat32(ext32(cov[0]) + ext32(R_D0));
          s11   <= sat32(ext32(cov[10]) + ext32(R_D1));
          s01   <= cov[2];
          s10   <= cov[8];
          state <= S_UD_MAC;
        end

        // zero determinant skips the correction
        S_UD_WR: begin
          if (acc == '0) begin
            sing  <= 1'b1;
            state <= S_FIN;
          end else begin
            det   <= acc[NUM_W-1:0];
            state <= S_UY;
          end
        end

        S_UY: begin
          y0    <= 33'(zx) - 33'(x[0]);
          y1    <= 33'(zt) - 33'(x[2]);
          ci    <= '0;
          cj    <= '0;
          state <= S_UN_MAC;
        end

        // gain numerator ready, hand it to the divider
        S_UN_WR: begin
          div_start <= 1'b1;
          state     <= S_UN_WAIT;
        end
        S_UN_WAIT: begin
          if (div_rsp.done) begin
            kg[gidx] <= div_rsp.quo;
            if (gidx == 3'd7) begin
              ci    <= '0;
              cj    <= '0;
              state <= S_UX_MAC;
            end else begin
              ci    <= 2'(3'(gidx + 3'd1) >> 1);
              cj    <= {1'b0, ~cj[0]};
              state <= S_UN_MAC;
            end
          end
        end

        // single products, each rounded on its own
        S_UX_MAC, S_UP_MAC: begin
          ph <= !ph;
          if (ph) state <= (state == S_UX_MAC) ? S_UX_ADD : S_UP_ADD;
        end

        // x = x + K*y
        S_UX_ADD: begin
          if (k == 3'd0) begin
            tsum  <= TS_W'(x[ci]) + acc_r24;
            k     <= 3'd1;
            state <= S_UX_MAC;
          end else begin
            x[ci] <= sat32(ext_ts(tsum) + ext_ts(acc_r24));
            k     <= '0;
            ci    <= ci + 2'd1;
            state <= (ci == 2'd3) ? S_UP_MAC : S_UX_MAC;
          end
        end

        // P = P - K*H*P into scratch, old P still read
        S_UP_ADD: begin
          if (k == 3'd0) begin
            tsum  <= TS_W'(p_rd) - acc_r24;
            k     <= 3'd1;
            state <= S_UP_MAC;
          end else begin
            ap[{ci, cj}] <= OPA_W'(sat32(ext_ts(tsum) - ext_ts(acc_r24)));
            k            <= '0;
            {ci, cj}     <= {ci, cj} + 4'd1;
            state        <= ({ci, cj} == 4'd15) ? S_UP_CP : S_UP_MAC;
          end
        end
        S_UP_CP: begin
          for (int i = 0; i < 16; i++) cov[i] <= ap[i][31:0];
          state <= S_FIN;
        end

        // load the output register once it is free
        S_FIN: begin
          if (fin_load) begin
            est.est_position     <= x[0];
            est.est_velocity     <= x[1];
            est.est_angle        <= x[2];
            est.est_angular_rate <= x[3];
            est.singular         <= sing;
            est.valid            <= 1'b1;
            state                <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* tb/sv/kalman_filter_four_state_tb.sv */
// ----------------------------------------------------------------------------
// kalman_filter_four_state_tb
// self-checking bench for the four-state kalman filter: a queue-fed command
// driver with bursts and gaps, a stalling estimate receiver, an apb register
// writer and a bit-exact fixed-point predictor checked per transfer
// ----------------------------------------------------------------------------
module kalman_filter_four_state_tb;
  import kf4_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [1:0]         act;
    logic signed [31:0] u;
    logic signed [31:0] zp;
    logic signed [31:0] za;
  } filter_cmd_t;

  typedef struct {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] ang;
    logic signed [31:0] rate;
    logic               sing;
  } estimate_t;

  // register indexes
  localparam int REG_A0   = 0;
  localparam int REG_A1   = 1;
  localparam int REG_A2   = 2;
  localparam int REG_A3   = 3;
  localparam int REG_B    = 4;
  localparam int REG_INIT = 5;

  // unused action code, the block must leave its state alone
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // process and measurement noise in q4.28
  localparam int signed Q_NOISE [4] = '{268435, 268435456, 26844, 2684355};
  localparam int signed R_POS   = 13421773;
  localparam int signed R_ANG   = 1342177;
  localparam int signed P_ONE   = 268435456;
  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  localparam int CYCLE_LIMIT = 4000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  kf4_cmd_if cmd ();
  kf4_est_if est ();

  kalman_filter_four_state uut (
    .clk(clk), .rst(rst), .cmd(cmd.sink), .est(est.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // shadow copy of the filter: registers, estimate and covariance
  logic [63:0]        sh_a_row [4];
  logic [63:0]        sh_b_gain;
  logic [63:0]        sh_init;
  logic signed [31:0] sh_x [4];
  logic signed [31:0] sh_p [16];

  filter_cmd_t pending_cmds [$];
  estimate_t   expected_estimates [$];
  int          mismatches = 0;
  longint      cycles = 0;

  // ---------------------------------------------------------------- arithmetic

  function automatic wide_t round_shift(wide_t v, int s);
    return (v + (wide_t'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(wide_t v);
    if (v > wide_t'(S32_MAX)) return S32_MAX;
    if (v < wide_t'(S32_MIN)) return S32_MIN;
    return v[31:0];
  endfunction

  function automatic wide_t coef(logic [63:0] w, int j);
    logic signed [15:0] e;
    e = w[16*j +: 16];
    return wide_t'(e);
  endfunction

  // (num << 24) / den truncated toward zero, clamped to q8.24
  function automatic logic signed [31:0] gain_quot(wide_t num, wide_t den);
    logic        neg;
    logic [127:0] n, d, q;
    neg = (num < 0) != (den < 0);
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    q = (n << 24) / d;
    if (neg) return (q >= 128'h8000_0000) ? S32_MIN : -q[31:0];
    return (q > 128'h7fff_ffff) ? S32_MAX : q[31:0];
  endfunction

  function automatic logic [63:0] pack4(logic [15:0] e0, logic [15:0] e1,
                                        logic [15:0] e2, logic [15:0] e3);
    return {e3, e2, e1, e0};
  endfunction

  // time update: x = a*x + b*u, p = a*p*a' + q
  function automatic void predict_step(logic signed [31:0] u);
    wide_t acc;
    wide_t ap [16];
    logic signed [31:0] xn [4];
    for (int i = 0; i < 4; i++) begin
      acc = coef(sh_b_gain, i) * wide_t'(u);
      for (int j = 0; j < 4; j++) acc += coef(sh_a_row[i], j) * wide_t'(sh_x[j]);
      xn[i] = clamp32(round_shift(acc, 11));
    end
    sh_x = xn;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += coef(sh_a_row[i], k) * wide_t'(sh_p[k*4+j]);
        ap[i*4+j] = round_shift(acc, 11);
      end
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += ap[i*4+k] * coef(sh_a_row[j], k);
        acc = round_shift(acc, 11);
        if (i == j) acc += wide_t'(Q_NOISE[i]);
        sh_p[i*4+j] = clamp32(acc);
      end
  endfunction

  // measurement update on position and angle, returns the singular flag
  function automatic logic correct_step(logic signed [31:0] zp, logic signed [31:0] za);
    wide_t s00, s01, s10, s11, det, y0, y1, p0, p2;
    logic signed [31:0] kg [4][2];
    logic signed [31:0] pn [16];
    s00 = wide_t'(clamp32(wide_t'(sh_p[0]) + R_POS));
    s01 = wide_t'(sh_p[2]);
    s10 = wide_t'(sh_p[8]);
    s11 = wide_t'(clamp32(wide_t'(sh_p[10]) + R_ANG));
    det = s00 * s11 - s10 * s01;
    if (det == 0) return 1'b1;
    y0 = wide_t'(zp) - wide_t'(sh_x[0]);
    y1 = wide_t'(za) - wide_t'(sh_x[2]);
    for (int i = 0; i < 4; i++) begin
      p0 = wide_t'(sh_p[i*4]);
      p2 = wide_t'(sh_p[i*4+2]);
      kg[i][0] = gain_quot(p0 * s11 - p2 * s10, det);
      kg[i][1] = gain_quot(p2 * s00 - p0 * s01, det);
    end
    for (int i = 0; i < 4; i++)
      sh_x[i] = clamp32(wide_t'(sh_x[i]) + round_shift(wide_t'(kg[i][0]) * y0, 24)
                        + round_shift(wide_t'(kg[i][1]) * y1, 24));
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        pn[i*4+j] = clamp32(wide_t'(sh_p[i*4+j])
                            - round_shift(wide_t'(kg[i][0]) * wide_t'(sh_p[j]), 24)
                            - round_shift(wide_t'(kg[i][1]) * wide_t'(sh_p[8+j]), 24));
    sh_p = pn;
    return 1'b0;
  endfunction

  function automatic void load_identity();
    for (int i = 0; i < 16; i++) sh_p[i] = (i % 5 == 0) ? P_ONE : 0;
  endfunction

  function automatic estimate_t filter_model(filter_cmd_t c);
    estimate_t r;
    r.sing = 1'b0;
    case (c.act)
      ACT_PREDICT: predict_step(c.u);
      ACT_UPDATE:  r.sing = correct_step(c.zp, c.za);
      ACT_RESTART: begin
        // q8.8 entries widened to q16.16
        for (int i = 0; i < 4; i++) sh_x[i] = clamp32(coef(sh_init, i) <<< 8);
        load_identity();
      end
      default: ;
    endcase
    r.pos = sh_x[0];
    r.vel = sh_x[1];
    r.ang = sh_x[2];
    r.rate = sh_x[3];
    return r;
  endfunction

  function automatic void shadow_reset();
    sh_a_row[0] = 64'd2048;
    sh_a_row[1] = 64'd134217728;
    sh_a_row[2] = 64'd8796093022208;
    sh_a_row[3] = 64'd576460752303423488;
    sh_b_gain = '0;
    sh_init = '0;
    for (int i = 0; i < 4; i++) sh_x[i] = 0;
    load_identity();
  endfunction

  // ------------------------------------------------------------ register port

  // setup then access phase, changes at falling edges
  task automatic reg_write(int idx, logic [63:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 6'(8 * idx);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_A0, REG_A1, REG_A2, REG_A3: sh_a_row[idx] = value;
      REG_B:    sh_b_gain = value;
      REG_INIT: sh_init = value;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? S32_MAX : S32_MIN;
      2, 3: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
      default: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    endcase
  endfunction

  function automatic filter_cmd_t rand_cmd(logic [1:0] act);
    filter_cmd_t c;
    c.act = act;
    c.u = rand_value();
    c.zp = rand_value();
    c.za = rand_value();
    return c;
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(0, 128)) - 64);
    endcase
  endfunction

  // mostly a stable model near identity, sometimes wild entries
  task automatic random_config();
    logic [15:0] e [4];
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) e[j] = rand_coef();
      if ($urandom_range(0, 3) != 0) e[i] = 16'(2048 + $signed($urandom_range(0, 64)) - 32);
      reg_write(REG_A0 + i, pack4(e[0], e[1], e[2], e[3]));
    end
    reg_write(REG_B, pack4(rand_coef(), rand_coef(), rand_coef(), rand_coef()));
    reg_write(REG_INIT, {$urandom(), $urandom()});
  endtask

  // restart, then predict/update pairs with random content and some noise
  task automatic queue_sequence(int count);
    pending_cmds.push_back(rand_cmd(ACT_RESTART));
    for (int n = 1; n < count; n++) begin
      case ($urandom_range(0, 19))
        0: pending_cmds.push_back(rand_cmd(ACT_UNUSED));
        1: pending_cmds.push_back(rand_cmd(ACT_RESTART));
        2, 3: pending_cmds.push_back(rand_cmd(2'($urandom_range(0, 1))));
        default: pending_cmds.push_back(rand_cmd((n % 2) ? ACT_PREDICT : ACT_UPDATE));
      endcase
    end
  endtask

  task automatic queue_cmd(logic [1:0] act, logic signed [31:0] u,
                           logic signed [31:0] zp, logic signed [31:0] za);
    filter_cmd_t c;
    c.act = act;
    c.u = u;
    c.zp = zp;
    c.za = za;
    pending_cmds.push_back(c);
  endtask

  // all transfers done and the block back at rest
  task automatic drain();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || cmd.valid || expected_estimates.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // ------------------------------------------------------------ command driver

  logic cmd_taken = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;

  initial begin
    cmd.valid = 1'b0;
    cmd.action = ACT_PREDICT;
    cmd.control_input = '0;
    cmd.measured_position = '0;
    cmd.measured_angle = '0;
    est.ready = 1'b0;
  end

  always @(posedge clk) cmd_taken <= cmd.valid && cmd.ready;

  // hold an offered command until its transfer, bursts separated by gaps
  always @(negedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
    end else if (cmd.valid && !cmd_taken) begin
      // keep offering
    end else if (gap_left > 0) begin
      cmd.valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_cmds.size() != 0) begin
      filter_cmd_t c;
      c = pending_cmds.pop_front();
      cmd.valid <= 1'b1;
      cmd.action <= c.act;
      cmd.control_input <= c.u;
      cmd.measured_position <= c.zp;
      cmd.measured_angle <= c.za;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 8);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      cmd.valid <= 1'b0;
    end
  end

  // every accepted command advances the shadow filter
  always @(posedge clk) begin
    if (!rst && cmd.valid && cmd.ready) begin
      filter_cmd_t c;
      c.act = cmd.action;
      c.u = cmd.control_input;
      c.zp = cmd.measured_position;
      c.za = cmd.measured_angle;
      expected_estimates.push_back(filter_model(c));
    end
  end

  // ------------------------------------------------------------ estimate side

  // receiver switches between always ready, coin flips and long stalls
  int ready_mode = 0;
  int mode_left = 0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 2);
      mode_left <= $urandom_range(50, 600);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      0: est.ready <= 1'b1;
      1: est.ready <= $urandom_range(0, 1);
      default: est.ready <= ($urandom_range(0, 39) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && est.valid && est.ready) begin
      if (expected_estimates.size() == 0) begin
        $display("%0t: estimate transfer with nothing expected pos=%0d", $time,
                 est.est_position);
        mismatches++;
      end else begin
        estimate_t e;
        e = expected_estimates.pop_front();
        if (est.est_position !== e.pos) begin
          $display("%0t: est_position expected %0d actual %0d", $time, e.pos, est.est_position);
          mismatches++;
        end
        if (est.est_velocity !== e.vel) begin
          $display("%0t: est_velocity expected %0d actual %0d", $time, e.vel, est.est_velocity);
          mismatches++;
        end
        if (est.est_angle !== e.ang) begin
          $display("%0t: est_angle expected %0d actual %0d", $time, e.ang, est.est_angle);
          mismatches++;
        end
        if (est.est_angular_rate !== e.rate) begin
          $display("%0t: est_angular_rate expected %0d actual %0d", $time, e.rate,
                   est.est_angular_rate);
          mismatches++;
        end
        if (est.singular !== e.sing) begin
          $display("%0t: singular expected %0b actual %0b", $time, e.sing, est.singular);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ------------------------------------------------------------------ sequence

  initial begin
    shadow_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset defaults: identity model, extremes of every input field
    queue_cmd(ACT_PREDICT, S32_MAX, 0, 0);
    queue_cmd(ACT_UPDATE, 0, S32_MAX, S32_MIN);
    queue_cmd(ACT_UPDATE, 0, S32_MIN, S32_MAX);
    queue_cmd(ACT_PREDICT, S32_MIN, S32_MAX, S32_MIN);
    queue_cmd(ACT_UNUSED, S32_MAX, S32_MAX, S32_MAX);
    queue_cmd(ACT_UPDATE, -1, -1, -1);
    queue_cmd(ACT_RESTART, -1, -1, -1);
    queue_cmd(ACT_UPDATE, 0, 0, 0);
    drain();

    // cart-pendulum like model with full-range gain and extreme start state
    reg_write(REG_A0, pack4(16'd2048, 16'd20, 16'd0, 16'd0));
    reg_write(REG_A1, pack4(16'd0, 16'd2048, 16'hffec, 16'd0));
    reg_write(REG_A2, pack4(16'd0, 16'd0, 16'd2048, 16'd20));
    reg_write(REG_A3, pack4(16'd0, 16'd0, 16'd2100, 16'd2048));
    reg_write(REG_B, pack4(16'h7fff, 16'h8000, 16'd1, 16'hffff));
    reg_write(REG_INIT, pack4(16'h7fff, 16'h8000, 16'h0001, 16'hffff));
    queue_cmd(ACT_RESTART, 0, 0, 0);
    queue_cmd(ACT_PREDICT, S32_MAX, 0, 0);
    queue_cmd(ACT_PREDICT, S32_MIN, 0, 0);
    queue_cmd(ACT_UPDATE, 0, 32'sh00010000, 32'shffff0000);
    drain();

    // identical rows 0 and 2 at full scale drive the innovation covariance
    // into saturation until its determinant vanishes
    reg_write(REG_A0, pack4(16'h7fff, 16'h0, 16'h7fff, 16'h0));
    reg_write(REG_A2, pack4(16'h7fff, 16'h0, 16'h7fff, 16'h0));
    reg_write(REG_A1, pack4(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    reg_write(REG_A3, pack4(16'h0, 16'h0, 16'h0, 16'h0));
    queue_cmd(ACT_RESTART, 0, 0, 0);
    for (int i = 0; i < 4; i++) queue_cmd(ACT_PREDICT, 32'sh00010000, 0, 0);
    queue_cmd(ACT_UPDATE, 0, S32_MAX, S32_MIN);
    queue_cmd(ACT_UPDATE, 0, 5, 7);
    drain();

    // random phases, each under its own register setting
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 3) begin
        for (int i = 0; i < 4; i++) reg_write(REG_A0 + i, 64'h8000_8000_8000_8000);
        reg_write(REG_B, 64'h7fff_7fff_7fff_7fff);
        reg_write(REG_INIT, 64'h8000_7fff_8000_7fff);
      end else if (ph == 5) begin
        for (int i = 0; i < 4; i++) reg_write(REG_A0 + i, 64'h0);
        reg_write(REG_B, 64'h0);
        reg_write(REG_INIT, 64'h0);
      end else begin
        random_config();
      end
      queue_sequence(148);
      drain();
    end

    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/kf4_pkg.sv
hdl/kf4_if.sv
hdl/kf4_mac.sv
hdl/kf4_div.sv
hdl/kalman_filter_four_state.sv
tb/sv/kalman_filter_four_state_tb.sv
